### hdl/pip_pkg.sv
`default_nettype none
package pip_pkg;

  localparam int COORD_WIDTH      = 24;
  localparam int CROSS_W          = 48;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 24;
  localparam int AREA_TOL_W       = 16;
  localparam int LEN_TOL_W        = 8;
  localparam int MAX_VERTICES_DEF = 64;

  localparam logic [AREA_TOL_W-1:0]         AREA_TOL_RST = AREA_TOL_W'(1);
  localparam logic [LEN_TOL_W-1:0]          LEN_TOL_RST  = LEN_TOL_W'(0);
  localparam logic signed [COORD_WIDTH-1:0] RAY_X_RST    = COORD_WIDTH'(512000);
  localparam logic signed [COORD_WIDTH-1:0] RAY_Y_RST    = COORD_WIDTH'(513280);

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BND_INSIDE = 3'd0,
    CFG_AREA_TOL   = 3'd1,
    CFG_LEN_TOL    = 3'd2,
    CFG_RAY_X      = 3'd3,
    CFG_RAY_Y      = 3'd4
  } cfg_idx_e;

  // Cross product operand orders, written as (a, b, c).
  typedef enum logic [3:0] {
    X_VPQ  = 4'd0,
    X_MPQ  = 4'd1,
    X_PVM  = 4'd2,
    X_QVM  = 4'd3,
    X_PQV  = 4'd4,
    X_PQM  = 4'd5,
    X_VMP  = 4'd6,
    X_MQV  = 4'd7,
    X_MVPR = 4'd8
  } xsel_e;

  localparam int XSEL_N = 9;

  typedef enum logic [1:0] {
    D_P  = 2'd0,
    D_Q  = 2'd1,
    D_PR = 2'd2
  } dst_e;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
  } pt_t;

  typedef struct packed {
    logic  vtx_wr;
    logic  v_cap;
    logic  rd_en;
    dst_e  rd_dst;
    logic  x_issue;
    xsel_e x_sel;
    logic  ev1;
    logic  ev2;
  } dp_cmd_t;

  typedef struct packed {
    logic bnd_hit;
    logic in_poly;
  } dp_sts_t;

endpackage
`default_nettype wire

### hdl/pip_in_if.sv
`default_nettype none
interface pip_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   command;
  logic signed [pip_pkg::COORD_WIDTH-1:0] coord_x;
  logic signed [pip_pkg::COORD_WIDTH-1:0] coord_y;
  logic                                   last_vertex;

  modport source (output valid, command, coord_x, coord_y, last_vertex, input ready);
  modport sink (input valid, command, coord_x, coord_y, last_vertex, output ready);
endinterface
`default_nettype wire

### hdl/pip_out_if.sv
`default_nettype none
interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic on_boundary;

  modport source (output valid, inside_res, on_boundary, input ready);
  modport sink (input valid, inside_res, on_boundary, output ready);
endinterface
`default_nettype wire

### hdl/pip_ram.sv
`default_nettype none
module pip_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### hdl/pip_cross.sv
`default_nettype none
module pip_cross (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   vld_i,
  input  pip_pkg::xsel_e                              tag_i,
  input  pip_pkg::pt_t                                a_i,
  input  pip_pkg::pt_t                                b_i,
  input  pip_pkg::pt_t                                c_i,
  output logic                                        vld_o,
  output pip_pkg::xsel_e                              tag_o,
  output logic signed [pip_pkg::CROSS_W-1:0]          res_o
);

  localparam int CW = pip_pkg::COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int XW = pip_pkg::CROSS_W;

  logic signed [DW-1:0] d1_d, e1_d, d2_d, e2_d;
  logic signed [DW-1:0] d1_q, e1_q, d2_q, e2_q;
  logic signed [PW-1:0] p1_d, p2_d, p1_q, p2_q;
  logic signed [PW:0]   r;
  logic [PW-XW+1:0]     top;
  logic [XW-1:0]        res_d;
  logic                 v0_q, v1_q;
  pip_pkg::xsel_e       t0_q, t1_q;

  always_comb begin
    d1_d = $signed({a_i.x[CW-1], a_i.x}) - $signed({b_i.x[CW-1], b_i.x});
    e1_d = $signed({c_i.y[CW-1], c_i.y}) - $signed({a_i.y[CW-1], a_i.y});
    d2_d = $signed({a_i.x[CW-1], a_i.x}) - $signed({c_i.x[CW-1], c_i.x});
    e2_d = $signed({b_i.y[CW-1], b_i.y}) - $signed({a_i.y[CW-1], a_i.y});
    p1_d = d1_q * e1_q;
    p2_d = d2_q * e2_q;
    r    = $signed({p1_q[PW-1], p1_q}) - $signed({p2_q[PW-1], p2_q});
    top  = r[PW:XW-1];
    if ((&top) || !(|top)) begin
      res_d = r[XW-1:0];
    end else if (r[PW]) begin
      res_d = {1'b1, {(XW-1){1'b0}}};
    end else begin
      res_d = {1'b0, {(XW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    d1_q  <= d1_d;
    e1_q  <= e1_d;
    d2_q  <= d2_d;
    e2_q  <= e2_d;
    p1_q  <= p1_d;
    p2_q  <= p2_d;
    res_o <= res_d;
    t0_q  <= tag_i;
    t1_q  <= t0_q;
    tag_o <= t1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      vld_o <= 1'b0;
    end else begin
      v0_q  <= vld_i;
      v1_q  <= v0_q;
      vld_o <= v1_q;
    end
  end

endmodule
`default_nettype wire

### hdl/pip_dp.sv
`default_nettype none
module pip_dp #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  pip_pkg::dp_cmd_t                             cmd_i,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]         wr_addr_i,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]         rd_addr_i,
  input  wire logic signed [pip_pkg::COORD_WIDTH-1:0]  in_x_i,
  input  wire logic signed [pip_pkg::COORD_WIDTH-1:0]  in_y_i,
  input  wire logic [pip_pkg::AREA_TOL_W-1:0]          area_tol_i,
  input  wire logic [pip_pkg::LEN_TOL_W-1:0]           len_tol_i,
  input  wire logic signed [pip_pkg::COORD_WIDTH-1:0]  ray_x_i,
  input  wire logic signed [pip_pkg::COORD_WIDTH-1:0]  ray_y_i,
  output pip_pkg::dp_sts_t                             sts_o
);

  localparam int CW    = pip_pkg::COORD_WIDTH;
  localparam int DW    = CW + 1;
  localparam int XW    = pip_pkg::CROSS_W;
  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CNT_W = AW + 2;

  function automatic logic [DW-1:0] dmag(input logic signed [CW-1:0] a,
                                         input logic signed [CW-1:0] b);
    logic signed [DW-1:0] d;
    d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    return d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  // Manhattan bound on one axis: point a between b and c with slack.
  function automatic logic manh(input logic signed [CW-1:0] a,
                                input logic signed [CW-1:0] b,
                                input logic signed [CW-1:0] c,
                                input logic [pip_pkg::LEN_TOL_W-1:0] lt);
    logic [DW:0] l;
    logic [DW:0] r;
    l = {1'b0, dmag(a, b)} + {1'b0, dmag(a, c)};
    r = {1'b0, dmag(b, c)} + (DW+1)'(lt);
    return l <= r;
  endfunction

  function automatic logic [XW-1:0] xmag(input logic signed [XW-1:0] v);
    return v[XW-1] ? XW'(-v) : XW'(v);
  endfunction

  pip_pkg::pt_t v_q, p_q, q_q, pr_q, m, xa, xb, xc, rd_pt;
  logic [2*CW-1:0]       rdata;
  logic                  rd_vld_q;
  pip_pkg::dst_e         rd_dst_q;
  logic                  x_vld;
  pip_pkg::xsel_e        x_tag;
  logic signed [XW-1:0]  x_res;
  logic signed [XW-1:0]  cr_q [pip_pkg::XSEL_N];
  logic [XW-1:0]         mg [pip_pkg::XSEL_N];
  logic [XW-1:0]         at;
  logic                  oe_vpq, oe_mpq, oe_pvm, oe_qvm, same, sgn_ok;
  logic                  early_q, sgn_ok_q, rsmall_q, c7pos_q, c8nn_q, c4pos_q;
  logic [XW:0]           s12_q, s34_q, t1_q, t2_q, t3_q, t4_q;
  logic                  meet;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  assign m.x = ray_x_i;
  assign m.y = ray_y_i;
  assign at  = XW'(area_tol_i);

  pip_ram #(
    .WIDTH(2 * CW),
    .DEPTH(MAX_VERTICES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.vtx_wr),
    .waddr_i(wr_addr_i),
    .wdata_i({in_x_i, in_y_i}),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_addr_i),
    .rdata_o(rdata)
  );

  assign rd_pt.x = rdata[2*CW-1:CW];
  assign rd_pt.y = rdata[CW-1:0];

  always_comb begin
    unique case (cmd_i.x_sel)
      pip_pkg::X_VPQ:  begin xa = v_q; xb = p_q; xc = q_q;  end
      pip_pkg::X_MPQ:  begin xa = m;   xb = p_q; xc = q_q;  end
      pip_pkg::X_PVM:  begin xa = p_q; xb = v_q; xc = m;    end
      pip_pkg::X_QVM:  begin xa = q_q; xb = v_q; xc = m;    end
      pip_pkg::X_PQV:  begin xa = p_q; xb = q_q; xc = v_q;  end
      pip_pkg::X_PQM:  begin xa = p_q; xb = q_q; xc = m;    end
      pip_pkg::X_VMP:  begin xa = v_q; xb = m;   xc = p_q;  end
      pip_pkg::X_MQV:  begin xa = m;   xb = q_q; xc = v_q;  end
      pip_pkg::X_MVPR: begin xa = m;   xb = v_q; xc = pr_q; end
      default:         begin xa = v_q; xb = p_q; xc = q_q;  end
    endcase
  end

  pip_cross u_cross (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (cmd_i.x_issue),
    .tag_i (cmd_i.x_sel),
    .a_i   (xa),
    .b_i   (xb),
    .c_i   (xc),
    .vld_o (x_vld),
    .tag_o (x_tag),
    .res_o (x_res)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.v_cap) begin
      v_q.x <= in_x_i;
      v_q.y <= in_y_i;
    end
    if (rd_vld_q) begin
      unique case (rd_dst_q)
        pip_pkg::D_P:  p_q  <= rd_pt;
        pip_pkg::D_Q:  q_q  <= rd_pt;
        pip_pkg::D_PR: pr_q <= rd_pt;
        default:       pr_q <= rd_pt;
      endcase
    end
    rd_dst_q <= cmd_i.rd_dst;
  end

  for (genvar k = 0; k < pip_pkg::XSEL_N; k++) begin : g_cr
    always_ff @(posedge clk_i) begin
      if (x_vld && (x_tag == pip_pkg::xsel_e'(k))) begin
        cr_q[k] <= x_res;
      end
    end
    assign mg[k] = xmag(cr_q[k]);
  end

  always_comb begin
    oe_vpq = (mg[pip_pkg::X_VPQ] <= at) && manh(v_q.x, p_q.x, q_q.x, len_tol_i)
             && manh(v_q.y, p_q.y, q_q.y, len_tol_i);
    oe_mpq = (mg[pip_pkg::X_MPQ] <= at) && manh(m.x, p_q.x, q_q.x, len_tol_i)
             && manh(m.y, p_q.y, q_q.y, len_tol_i);
    oe_pvm = (mg[pip_pkg::X_PVM] <= at) && manh(p_q.x, v_q.x, m.x, len_tol_i)
             && manh(p_q.y, v_q.y, m.y, len_tol_i);
    oe_qvm = (mg[pip_pkg::X_QVM] <= at) && manh(q_q.x, v_q.x, m.x, len_tol_i)
             && manh(q_q.y, v_q.y, m.y, len_tol_i);
    same   = (v_q == p_q) || (m == p_q) || (m == q_q) || (v_q == q_q);
    sgn_ok = (cr_q[pip_pkg::X_PQV] == '0) || (cr_q[pip_pkg::X_PQM] == '0)
             || (cr_q[pip_pkg::X_PQV][XW-1] != cr_q[pip_pkg::X_PQM][XW-1]);
    meet   = early_q || (sgn_ok_q && !((s12_q < t3_q) || (s12_q < t4_q)
             || (s34_q < t1_q) || (s34_q < t2_q)));
    cnt_d  = cnt_q;
    if (meet) begin
      if (rsmall_q) begin
        if (c8nn_q) begin
          cnt_d = c7pos_q ? cnt_q + CNT_W'(1) : cnt_q - CNT_W'(1);
        end
      end else begin
        cnt_d = c4pos_q ? cnt_q + CNT_W'(1) : cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ev1) begin
      early_q  <= same || oe_vpq || oe_mpq || oe_pvm || oe_qvm;
      sgn_ok_q <= sgn_ok;
      s12_q    <= {1'b0, mg[pip_pkg::X_PQV]} + {1'b0, mg[pip_pkg::X_PQM]};
      s34_q    <= {1'b0, mg[pip_pkg::X_PVM]} + {1'b0, mg[pip_pkg::X_QVM]};
      t1_q     <= {1'b0, mg[pip_pkg::X_PQV]} + {1'b0, at};
      t2_q     <= {1'b0, mg[pip_pkg::X_PQM]} + {1'b0, at};
      t3_q     <= {1'b0, mg[pip_pkg::X_PVM]} + {1'b0, at};
      t4_q     <= {1'b0, mg[pip_pkg::X_QVM]} + {1'b0, at};
      rsmall_q <= mg[pip_pkg::X_VMP] <= at;
      c7pos_q  <= !cr_q[pip_pkg::X_MQV][XW-1] && (cr_q[pip_pkg::X_MQV] != '0);
      c8nn_q   <= !cr_q[pip_pkg::X_MVPR][XW-1];
      c4pos_q  <= !cr_q[pip_pkg::X_PQV][XW-1] && (cr_q[pip_pkg::X_PQV] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.v_cap) begin
        cnt_q <= '0;
      end else if (cmd_i.ev2) begin
        cnt_q <= cnt_d;
      end
    end
  end

  assign sts_o.bnd_hit = oe_vpq;
  assign sts_o.in_poly = !cnt_q[CNT_W-1] && (cnt_q != '0);

endmodule
`default_nettype wire

### hdl/pip_ctrl.sv
`default_nettype none
module pip_ctrl #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             in_cmd_i,
  input  wire logic                             in_last_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  out_inside_o,
  output logic                                  out_onb_o,
  input  wire logic                             bnd_inside_i,
  output pip_pkg::dp_cmd_t                      cmd_o,
  output logic [$clog2(MAX_VERTICES)-1:0]       wr_addr_o,
  output logic [$clog2(MAX_VERTICES)-1:0]       rd_addr_o,
  input  pip_pkg::dp_sts_t                      sts_i
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam logic [3:0] FETCH_LAST = 4'd2;
  localparam logic [3:0] WAIT_LAST  = 4'd2;
  localparam logic [3:0] XLAST      = 4'(pip_pkg::XSEL_N - 1);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_BFETCH = 12'b0000_0000_0010,
    S_BCROSS = 12'b0000_0000_0100,
    S_BWAIT  = 12'b0000_0000_1000,
    S_BEVAL  = 12'b0000_0001_0000,
    S_CFETCH = 12'b0000_0010_0000,
    S_CCROSS = 12'b0000_0100_0000,
    S_CWAIT  = 12'b0000_1000_0000,
    S_CEV1   = 12'b0001_0000_0000,
    S_CEV2   = 12'b0010_0000_0000,
    S_CFIN   = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_e;

  state_e      state_q, state_d;
  logic [AW:0] lp_q, lp_d, nv_q, nv_d, idx_q, idx_d, idx_nxt, idx_prv, lp_inc;
  logic [3:0]  step_q, step_d;
  logic        rin_q, rin_d, ron_q, ron_d;
  logic        ovld_d, oin_d, oon_d;
  logic        last_edge, accept, room;

  assign last_edge = idx_q == (nv_q - (AW+1)'(1));
  assign idx_nxt   = last_edge ? '0 : idx_q + (AW+1)'(1);
  assign idx_prv   = (idx_q == '0) ? nv_q - (AW+1)'(1) : idx_q - (AW+1)'(1);
  assign room      = lp_q < (AW+1)'(MAX_VERTICES);
  assign lp_inc    = room ? lp_q + (AW+1)'(1) : lp_q;
  assign accept    = in_valid_i && in_ready_o;
  assign wr_addr_o = lp_q[AW-1:0];
  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    lp_d    = lp_q;
    nv_d    = nv_q;
    idx_d   = idx_q;
    step_d  = step_q;
    rin_d   = rin_q;
    ron_d   = ron_q;
    ovld_d  = out_valid_o && !out_ready_i;
    oin_d   = out_inside_o;
    oon_d   = out_onb_o;
    cmd_o   = '0;
    rd_addr_o = idx_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        step_d = '0;
        idx_d  = '0;
        if (accept) begin
          if (in_cmd_i == pip_pkg::CMD_LOAD) begin
            cmd_o.vtx_wr = room;
            if (in_last_i) begin
              nv_d = lp_inc;
              lp_d = '0;
            end else begin
              lp_d = lp_inc;
            end
          end else begin
            cmd_o.v_cap = 1'b1;
            if (nv_q == '0) begin
              rin_d   = 1'b0;
              ron_d   = 1'b0;
              state_d = S_DONE;
            end else begin
              state_d = S_BFETCH;
            end
          end
        end
      end
      S_BFETCH, S_CFETCH: begin
        cmd_o.rd_en = 1'b1;
        unique case (step_q)
          4'd0: begin
            rd_addr_o    = idx_q[AW-1:0];
            cmd_o.rd_dst = pip_pkg::D_P;
          end
          4'd1: begin
            rd_addr_o    = idx_nxt[AW-1:0];
            cmd_o.rd_dst = pip_pkg::D_Q;
          end
          default: begin
            rd_addr_o    = idx_prv[AW-1:0];
            cmd_o.rd_dst = pip_pkg::D_PR;
          end
        endcase
        step_d = step_q + 4'd1;
        if (step_q == FETCH_LAST) begin
          step_d  = '0;
          state_d = (state_q == S_BFETCH) ? S_BCROSS : S_CCROSS;
        end
      end
      S_BCROSS: begin
        cmd_o.x_issue = 1'b1;
        cmd_o.x_sel   = pip_pkg::X_VPQ;
        state_d       = S_BWAIT;
      end
      S_CCROSS: begin
        cmd_o.x_issue = 1'b1;
        cmd_o.x_sel   = pip_pkg::xsel_e'(step_q);
        step_d        = step_q + 4'd1;
        if (step_q == XLAST) begin
          step_d  = '0;
          state_d = S_CWAIT;
        end
      end
      S_BWAIT, S_CWAIT: begin
        step_d = step_q + 4'd1;
        if (step_q == WAIT_LAST) begin
          step_d  = '0;
          state_d = (state_q == S_BWAIT) ? S_BEVAL : S_CEV1;
        end
      end
      S_BEVAL: begin
        if (sts_i.bnd_hit) begin
          rin_d   = bnd_inside_i;
          ron_d   = 1'b1;
          state_d = S_DONE;
        end else if (last_edge) begin
          idx_d   = '0;
          state_d = S_CFETCH;
        end else begin
          idx_d   = idx_nxt;
          state_d = S_BFETCH;
        end
      end
      S_CEV1: begin
        cmd_o.ev1 = 1'b1;
        state_d   = S_CEV2;
      end
      S_CEV2: begin
        cmd_o.ev2 = 1'b1;
        if (last_edge) begin
          state_d = S_CFIN;
        end else begin
          idx_d   = idx_nxt;
          state_d = S_CFETCH;
        end
      end
      S_CFIN: begin
        rin_d   = sts_i.in_poly;
        ron_d   = 1'b0;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_o || out_ready_i) begin
          ovld_d  = 1'b1;
          oin_d   = rin_q;
          oon_d   = ron_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lp_q        <= '0;
      nv_q        <= '0;
      idx_q       <= '0;
      step_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      lp_q        <= lp_d;
      nv_q        <= nv_d;
      idx_q       <= idx_d;
      step_q      <= step_d;
      out_valid_o <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rin_q        <= rin_d;
    ron_q        <= ron_d;
    out_inside_o <= oin_d;
    out_onb_o    <= oon_d;
  end

endmodule
`default_nettype wire

### hdl/point_in_polygon_test.sv
`default_nettype none
// Point-in-polygon test with edge detection. Load transactions append vertices
// to a store of MAX_VERTICES entries; the one flagged last closes the polygon.
// A load gives no result. A query walks the edges twice, first to find the
// point on an edge, then to count ray crossings. It stops as soon as the point
// is found on an edge, and with no polygon it skips both walks. Query time is
// set by the single pipelined cross-product unit, which is issued up to nine
// products per edge, and by the one read port of the vertex memory. A new
// transaction is accepted while a result still waits.
module point_in_polygon_test #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  pip_in_if.sink                                in_if,
  pip_out_if.source                             out_if,
  input  wire logic                             cfg_we_i,
  input  wire logic [pip_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [pip_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = pip_pkg::COORD_WIDTH;

  logic                                bnd_inside_q;
  logic [pip_pkg::AREA_TOL_W-1:0]      area_tol_q;
  logic [pip_pkg::LEN_TOL_W-1:0]       len_tol_q;
  logic signed [CW-1:0]                ray_x_q, ray_y_q;
  pip_pkg::dp_cmd_t                    cmd;
  pip_pkg::dp_sts_t                    sts;
  logic [AW-1:0]                       wr_addr, rd_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bnd_inside_q <= 1'b1;
      area_tol_q   <= pip_pkg::AREA_TOL_RST;
      len_tol_q    <= pip_pkg::LEN_TOL_RST;
      ray_x_q      <= pip_pkg::RAY_X_RST;
      ray_y_q      <= pip_pkg::RAY_Y_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pip_pkg::CFG_BND_INSIDE: bnd_inside_q <= cfg_wdata_i[0];
        pip_pkg::CFG_AREA_TOL:   area_tol_q   <= cfg_wdata_i[pip_pkg::AREA_TOL_W-1:0];
        pip_pkg::CFG_LEN_TOL:    len_tol_q    <= cfg_wdata_i[pip_pkg::LEN_TOL_W-1:0];
        pip_pkg::CFG_RAY_X:      ray_x_q      <= cfg_wdata_i[CW-1:0];
        pip_pkg::CFG_RAY_Y:      ray_y_q      <= cfg_wdata_i[CW-1:0];
        default: ;
      endcase
    end
  end

  pip_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .in_cmd_i    (in_if.command),
    .in_last_i   (in_if.last_vertex),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_inside_o(out_if.inside_res),
    .out_onb_o   (out_if.on_boundary),
    .bnd_inside_i(bnd_inside_q),
    .cmd_o       (cmd),
    .wr_addr_o   (wr_addr),
    .rd_addr_o   (rd_addr),
    .sts_i       (sts)
  );

  pip_dp #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .wr_addr_i (wr_addr),
    .rd_addr_i (rd_addr),
    .in_x_i    (in_if.coord_x),
    .in_y_i    (in_if.coord_y),
    .area_tol_i(area_tol_q),
    .len_tol_i (len_tol_q),
    .ray_x_i   (ray_x_q),
    .ray_y_i   (ray_y_q),
    .sts_o     (sts)
  );

endmodule
`default_nettype wire
